// File: sv/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the WebSocket deframer/unmasker modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_HEAD   = 4'd0,
    PH_LEN    = 4'd1,
    PH_EXT_HI = 4'd2,
    PH_EXT_LO = 4'd3,
    PH_MASK0  = 4'd4,
    PH_MASK1  = 4'd5,
    PH_MASK2  = 4'd6,
    PH_MASK3  = 4'd7,
    PH_DATA   = 4'd8
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_PONG = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNMASKED = 3'd1;
  localparam logic [2:0] ERR_LEN64    = 3'd2;
  localparam logic [2:0] ERR_EXT_LEN  = 3'd3;
  localparam logic [2:0] ERR_OPCODE   = 3'd4;
  localparam logic [2:0] ERR_PONG_MID = 3'd5;

  // frame constants
  localparam logic [7:0]  HEAD_PING   = 8'h89;
  localparam logic [7:0]  HEAD_PONG   = 8'h8A;
  localparam logic [6:0]  OP_MAX_DATA = 7'h02;
  localparam logic [6:0]  LEN_CODE_16 = 7'd126;
  localparam logic [6:0]  LEN_CODE_64 = 7'd127;
  localparam logic [15:0] MIN_EXT_LEN = 16'd126;

  // result queue
  localparam int QDEPTH = 4;
  localparam int LVL_W  = 3;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       has;
    logic       fl;
    logic       ml;
    logic [2:0] err;
  } res_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// File: sv/wsfd_parse.sv
// ----------------------------------------------------------------------------
// wsfd_parse
// Frame parser: header, length, mask key and payload unmasking, one byte
// per accepted transaction, with the results that byte produces.
// ----------------------------------------------------------------------------
module wsfd_parse import wsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  output push_t      push
);

  phase_t      phase, phase_next;
  logic [7:0]  head, head_next;
  logic [15:0] len, len_next;
  logic [31:0] key, key_next;
  logic [15:0] idx, idx_next;
  logic        frag_open, frag_open_next;
  logic        closed, closed_next;

  logic [15:0] ext_len;
  logic        ext_bad;
  logic        data_head;
  logic        len_zero;
  logic        data_last;
  logic [7:0]  key_byte;
  logic [7:0]  plain;
  logic        active;

  assign active    = take && !closed;
  assign ext_len   = {len[15:8], in_byte};
  assign ext_bad   = (ext_len < MIN_EXT_LEN) || (head[6:0] > OP_MAX_DATA);
  assign data_head = head[6:0] <= OP_MAX_DATA;
  assign len_zero  = len == 16'd0;
  assign data_last = ({1'b0, idx} + 17'd1) >= {1'b0, len};
  assign plain     = in_byte ^ key_byte;

  always_comb begin
    case (idx[1:0])
      2'd0:    key_byte = key[7:0];
      2'd1:    key_byte = key[15:8];
      2'd2:    key_byte = key[23:16];
      default: key_byte = key[31:24];
    endcase
  end

  // next state
  always_comb begin
    phase_next     = phase;
    head_next      = head;
    len_next       = len;
    key_next       = key;
    idx_next       = idx;
    frag_open_next = frag_open;
    closed_next    = closed;
    if (active) begin
      unique case (phase)
        PH_LEN: begin
          if (!in_byte[7] || in_byte[6:0] == LEN_CODE_64) begin
            closed_next = 1'b1;
          end else if (in_byte[6:0] == LEN_CODE_16) begin
            phase_next = PH_EXT_HI;
          end else begin
            len_next   = {9'd0, in_byte[6:0]};
            phase_next = PH_MASK0;
          end
        end
        PH_EXT_HI: begin
          len_next   = {in_byte, 8'd0};
          phase_next = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          len_next = ext_len;
          if (ext_bad) begin
            closed_next = 1'b1;
          end else begin
            phase_next = PH_MASK0;
          end
        end
        PH_MASK0: begin
          key_next   = {24'd0, in_byte};
          phase_next = PH_MASK1;
        end
        PH_MASK1: begin
          key_next[15:8] = in_byte;
          phase_next     = PH_MASK2;
        end
        PH_MASK2: begin
          key_next[23:16] = in_byte;
          phase_next      = PH_MASK3;
        end
        PH_MASK3: begin
          key_next[31:24] = in_byte;
          idx_next        = 16'd0;
          if (data_head) begin
            frag_open_next = !head[7];
            phase_next     = len_zero ? PH_HEAD : PH_DATA;
          end else if (head == HEAD_PING) begin
            phase_next = len_zero ? PH_HEAD : PH_DATA;
          end else if (head == HEAD_PONG && !frag_open) begin
            phase_next = len_zero ? PH_HEAD : PH_DATA;
          end else begin
            closed_next = 1'b1;
          end
        end
        PH_DATA: begin
          idx_next = idx + 16'd1;
          if (data_last) begin
            phase_next = PH_HEAD;
          end
        end
        default: begin
          head_next  = in_byte;
          phase_next = PH_LEN;
        end
      endcase
    end
  end

  // results
  always_comb begin
    push = '0;
    if (active) begin
      unique case (phase)
        PH_LEN: begin
          if (!in_byte[7]) begin
            push.n      = 2'd1;
            push.r0.kind = KIND_ERR;
            push.r0.err  = ERR_UNMASKED;
          end else if (in_byte[6:0] == LEN_CODE_64) begin
            push.n      = 2'd1;
            push.r0.kind = KIND_ERR;
            push.r0.err  = ERR_LEN64;
          end
        end
        PH_EXT_LO: begin
          if (ext_bad) begin
            push.n      = 2'd1;
            push.r0.kind = KIND_ERR;
            push.r0.err  = ERR_EXT_LEN;
          end
        end
        PH_MASK3: begin
          if (data_head) begin
            if (len_zero) begin
              // empty data frame: end marker only
              push.n       = 2'd1;
              push.r0.kind = KIND_DATA;
              push.r0.fl   = 1'b1;
              push.r0.ml   = head[7];
            end
          end else if (head == HEAD_PING) begin
            push.n       = 2'd2;
            push.r0.data = HEAD_PONG;
            push.r0.kind = KIND_PONG;
            push.r0.has  = 1'b1;
            push.r1.data = len[7:0];
            push.r1.kind = KIND_PONG;
            push.r1.has  = 1'b1;
            push.r1.fl   = len_zero;
          end else if (head == HEAD_PONG) begin
            if (frag_open) begin
              push.n       = 2'd1;
              push.r0.kind = KIND_ERR;
              push.r0.err  = ERR_PONG_MID;
            end
          end else begin
            push.n       = 2'd1;
            push.r0.kind = KIND_ERR;
            push.r0.err  = ERR_OPCODE;
          end
        end
        PH_DATA: begin
          if (head == HEAD_PING) begin
            push.n       = 2'd1;
            push.r0.data = plain;
            push.r0.kind = KIND_PONG;
            push.r0.has  = 1'b1;
            push.r0.fl   = data_last;
          end else if (head != HEAD_PONG) begin
            push.n       = 2'd1;
            push.r0.data = plain;
            push.r0.kind = KIND_DATA;
            push.r0.has  = 1'b1;
            push.r0.fl   = data_last;
            push.r0.ml   = data_last && head[7];
          end
        end
        default: begin
          push = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEAD;
      head      <= 8'd0;
      len       <= 16'd0;
      key       <= 32'd0;
      idx       <= 16'd0;
      frag_open <= 1'b0;
      closed    <= 1'b0;
    end else begin
      phase     <= phase_next;
      head      <= head_next;
      len       <= len_next;
      key       <= key_next;
      idx       <= idx_next;
      frag_open <= frag_open_next;
      closed    <= closed_next;
    end
  end

endmodule

// File: sv/wsfd_outq.sv
// ----------------------------------------------------------------------------
// wsfd_outq
// Four-entry shifting result queue; takes up to two results per cycle and
// presents the oldest at entry zero.
// ----------------------------------------------------------------------------
module wsfd_outq import wsfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  input  logic             pop,
  output res_t             head,
  output logic [LVL_W-1:0] level
);

  res_t             q      [QDEPTH];
  res_t             q_next [QDEPTH];
  logic [LVL_W-1:0] level_next;
  logic [LVL_W-1:0] lvl_after;

  assign lvl_after = level - {{(LVL_W-1){1'b0}}, pop};
  assign head      = q[0];

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if (push.n != 2'd0 && LVL_W'(i) == lvl_after) begin
        q_next[i] = push.r0;
      end
      if (push.n == 2'd2 && LVL_W'(i) == lvl_after + 1'b1) begin
        q_next[i] = push.r1;
      end
    end
    level_next = lvl_after + {{(LVL_W-2){1'b0}}, push.n};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else begin
      level <= level_next;
    end
  end

endmodule

// File: sv/websocket_frame_deframer_unmasker_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unmasker_unit
// Client-to-server WebSocket deframer: parses headers, unmasks payload,
// echoes pings as pongs and reports protocol errors.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | receive   | in_valid/in_stall  | in_byte
//  out     | send      | out_valid/out_stall| out_byte, out_kind, has_byte,
//          |           |                    | frame_last, message_last,
//          |           |                    | error_code
//
// Input: one byte per cycle while in_stall is low; its results are written to a four-entry
//   result queue at the same edge, and the out port shows the registered oldest entry.
// The out port delivers one result per cycle while out_stall is low; the ping header
//   step produces two results, the pong header and the ping length byte.
// in_stall rises while the queue holds three or more results, i.e. while it
//   cannot guarantee room for the two results of the next byte.
// Reset (rst, synchronous): parser returns to expecting a head byte, the
//   fragment and closed flags clear, and the result queue empties.
// After an error report the block keeps accepting bytes and drops them.
//
module websocket_frame_deframer_unmasker_unit import wsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       has_byte,
  output logic       frame_last,
  output logic       message_last,
  output logic [2:0] error_code
);

  logic             in_take;
  logic             out_take;
  push_t            push;
  res_t             q_head;
  logic [LVL_W-1:0] q_level;

  // input transaction taken this edge
  assign in_take  = in_valid && !in_stall;
  // room for two results needed before a byte is taken
  assign in_stall = q_level > LVL_W'(QDEPTH - 2);

  wsfd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (in_take),
    .in_byte (in_byte),
    .push    (push)
  );

  wsfd_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (out_take),
    .head  (q_head),
    .level (q_level)
  );

  // output transaction: oldest queued result
  assign out_valid    = q_level != '0;
  assign out_take     = out_valid && !out_stall;
  assign out_byte     = q_head.data;
  assign out_kind     = q_head.kind;
  assign has_byte     = q_head.has;
  assign frame_last   = q_head.fl;
  assign message_last = q_head.ml;
  assign error_code   = q_head.err;

  // error reports carry nothing but the code
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ERR |->
      !has_byte && !frame_last && !message_last && error_code != ERR_NONE)
    else $error("error report with stray fields");

  // non-error results never carry an error code
  a_no_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_ERR |-> error_code == ERR_NONE)
    else $error("error code on a non-error result");

  // a double push is only ever the pong header pair
  a_pair: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> push.r0.data == HEAD_PONG && push.r0.kind == KIND_PONG &&
      push.r1.kind == KIND_PONG)
    else $error("unexpected double result");

  // queue never overruns
  a_level: assert property (@(posedge clk) disable iff (rst)
    q_level <= LVL_W'(QDEPTH))
    else $error("result queue overrun");

  // results only follow an accepted byte
  a_push_take: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> in_take)
    else $error("result without input transaction");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - WebSocket deframer/unmasker testbench
// Streams masked client frames into the block byte by byte, with random idle
// cycles on both sides, and checks every result against a local model of the
// parser: empty frames, fragments, pings/pongs, 16-bit lengths, back-pressure,
// and finally one protocol error that closes the link.
// ----------------------------------------------------------------------------
module tb;
  import wsfd_pkg::*;

  localparam int LIMIT = 800000;   // cycles before the run is abandoned

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       has_byte;
  logic       frame_last;
  logic       message_last;
  logic [2:0] error_code;

  websocket_frame_deframer_unmasker_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_kind    (out_kind),
    .has_byte    (has_byte),
    .frame_last  (frame_last),
    .message_last(message_last),
    .error_code  (error_code)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser model state, kept in step with every accepted byte
  // --------------------------------------------------------------------------
  phase_t      phase;
  logic [7:0]  head;
  logic [15:0] frame_len;
  logic [31:0] mask_key;
  logic [15:0] pay_idx;
  logic        frag_open;
  logic        link_closed;

  res_t pending_results[$];   // results still owed by the block, oldest first

  // shared knobs between the stimulus and the two handshake processes
  bit no_gaps;                // both sides run flat out while set
  int hold_cycles;            // one-off long receiver hold-off, picked up once

  // bookkeeping
  int n_bytes, n_checked, n_mismatch, n_in_stall;
  int n_data_frames, n_pings, n_pongs;
  int close_code;
  int cycle_count;

  // --------------------------------------------------------------------------
  // Model helpers
  // --------------------------------------------------------------------------
  task automatic owe_result(input logic [7:0] data, input logic [1:0] kind,
                            input logic has, input logic fl, input logic ml,
                            input logic [2:0] err);
    res_t r;
    r.data = data;
    r.kind = kind;
    r.has  = has;
    r.fl   = fl;
    r.ml   = ml;
    r.err  = err;
    pending_results.push_back(r);
  endtask

  // an error is reported once; afterwards the link swallows everything
  task automatic close_link(input logic [2:0] code);
    owe_result(8'h00, KIND_ERR, 1'b0, 1'b0, 1'b0, code);
    link_closed = 1'b1;
    close_code  = int'(code);
  endtask

  // Advances the parser model by one received byte and queues what it owes.
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] v;
    logic       last;
    if (link_closed)
      return;
    case (phase)
      PH_LEN: begin
        if (!b[7])
          close_link(ERR_UNMASKED);
        else if (b[6:0] == LEN_CODE_64)
          close_link(ERR_LEN64);
        else if (b[6:0] == LEN_CODE_16)
          phase = PH_EXT_HI;
        else begin
          frame_len = {9'd0, b[6:0]};
          phase     = PH_MASK0;
        end
      end
      PH_EXT_HI: begin
        frame_len = {b, 8'h00};
        phase     = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        frame_len[7:0] = b;
        // 16-bit form must be minimal and is only legal on data frames
        if (frame_len < MIN_EXT_LEN || head[6:0] > OP_MAX_DATA)
          close_link(ERR_EXT_LEN);
        else
          phase = PH_MASK0;
      end
      PH_MASK0: begin
        mask_key = {24'd0, b};
        phase    = PH_MASK1;
      end
      PH_MASK1: begin
        mask_key[15:8] = b;
        phase          = PH_MASK2;
      end
      PH_MASK2: begin
        mask_key[23:16] = b;
        phase           = PH_MASK3;
      end
      PH_MASK3: begin
        // header complete: opcode decided here
        mask_key[31:24] = b;
        pay_idx         = 16'd0;
        if (head[6:0] <= OP_MAX_DATA) begin
          frag_open = !head[7];
          if (frame_len == 16'd0) begin
            phase = PH_HEAD;
            owe_result(8'h00, KIND_DATA, 1'b0, 1'b1, head[7], ERR_NONE);
          end else
            phase = PH_DATA;
        end else if (head == HEAD_PING) begin
          owe_result(HEAD_PONG, KIND_PONG, 1'b1, 1'b0, 1'b0, ERR_NONE);
          owe_result(frame_len[7:0], KIND_PONG, 1'b1, frame_len == 16'd0, 1'b0,
                     ERR_NONE);
          phase = (frame_len != 16'd0) ? PH_DATA : PH_HEAD;
        end else if (head == HEAD_PONG) begin
          if (frag_open)
            close_link(ERR_PONG_MID);
          else
            phase = (frame_len != 16'd0) ? PH_DATA : PH_HEAD;
        end else
          close_link(ERR_OPCODE);
      end
      PH_DATA: begin
        v       = b ^ mask_key[8*pay_idx[1:0] +: 8];
        last    = ({1'b0, pay_idx} + 17'd1) >= {1'b0, frame_len};
        pay_idx = pay_idx + 16'd1;
        if (last)
          phase = PH_HEAD;
        if (head == HEAD_PING)
          owe_result(v, KIND_PONG, 1'b1, last, 1'b0, ERR_NONE);
        else if (head != HEAD_PONG)
          owe_result(v, KIND_DATA, 1'b1, last, last & head[7], ERR_NONE);
      end
      default: begin
        head  = b;
        phase = PH_LEN;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender: one byte per call. Always entered just after a rising edge, and
  // leaves at the accepting edge with nothing scheduled, so the next call
  // makes the only assignment to in_valid in that time step.
  // --------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do begin
      @(posedge clk);
      if (in_stall)
        n_in_stall++;
    end while (in_stall);
    n_bytes++;
    deframe_byte(b);
  endtask

  // Full frame with random masked payload; lengths above 125 or ext16 use
  // the 16-bit form.
  task automatic send_frame(input logic [7:0] hd, input logic [15:0] len,
                            input bit ext16, input logic [31:0] key);
    if (hd[6:0] <= OP_MAX_DATA)
      n_data_frames++;
    else if (hd == HEAD_PING)
      n_pings++;
    else if (hd == HEAD_PONG)
      n_pongs++;
    offer_byte(hd);
    if (ext16 || len > 16'd125) begin
      offer_byte({1'b1, LEN_CODE_16});
      offer_byte(len[15:8]);
      offer_byte(len[7:0]);
    end else
      offer_byte({1'b1, len[6:0]});
    for (int i = 0; i < 4; i++)
      offer_byte(key[8*i +: 8]);
    for (int i = 0; i < len; i++)
      offer_byte(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall before each result, plus the one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int w;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_cycles > 0) begin
        w           = hold_cycles;
        hold_cycles = 0;
      end else
        w = no_gaps ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: values seen here are those before the edge
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      n_mismatch++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        n_mismatch++;
        $display("%0t: unexpected result, expected none, got byte %0d kind %0d err %0d",
                 $time, out_byte, out_kind, error_code);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("out_byte",     int'(want.data), int'(out_byte));
        check_field("out_kind",     int'(want.kind), int'(out_kind));
        check_field("has_byte",     int'(want.has),  int'(has_byte));
        check_field("frame_last",   int'(want.fl),   int'(frame_last));
        check_field("message_last", int'(want.ml),   int'(message_last));
        check_field("error_code",   int'(want.err),  int'(error_code));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // zero-length frames (end markers), fragments, key extremes, tiny pings
  task automatic test_empty_frames();
    send_frame(8'h81, 16'd0, 1'b0, $urandom);
    send_frame(8'h01, 16'd0, 1'b0, $urandom);      // opens a message
    send_frame(8'h00, 16'd0, 1'b0, $urandom);
    send_frame(8'h80, 16'd0, 1'b0, $urandom);      // closes it
    send_frame(8'h82, 16'd1, 1'b0, 32'hFFFF_FFFF);
    send_frame(8'h02, 16'd3, 1'b0, 32'h0000_0000);
    send_frame(8'h00, 16'd5, 1'b0, $urandom);
    send_frame(8'h80, 16'd1, 1'b0, $urandom);
    send_frame(HEAD_PING, 16'd0, 1'b0, $urandom);  // pong length byte ends frame
    send_frame(HEAD_PING, 16'd1, 1'b0, $urandom);
  endtask

  // echo of the longest short ping, discarded pongs, ping inside a message
  task automatic test_ping_pong();
    send_frame(HEAD_PING, 16'd125, 1'b0, $urandom);
    send_frame(HEAD_PONG, 16'd0, 1'b0, $urandom);
    send_frame(HEAD_PONG, 16'd5, 1'b0, $urandom);
    send_frame(8'h01, 16'd4, 1'b0, $urandom);
    send_frame(HEAD_PING, 16'd3, 1'b0, $urandom);
    send_frame(8'h80, 16'd2, 1'b0, $urandom);
    send_frame(8'h81, 16'd125, 1'b0, $urandom);
  endtask

  // 16-bit lengths: minimum, mid-range fragment, and a long frame at full rate
  task automatic test_extended_length();
    send_frame(8'h82, MIN_EXT_LEN, 1'b1, $urandom);
    send_frame(8'h01, 16'd150, 1'b1, $urandom);
    send_frame(8'h80, 16'd160, 1'b1, $urandom);
    no_gaps = 1'b1;
    send_frame(8'h82, 16'd260, 1'b1, $urandom);
    no_gaps = 1'b0;
  endtask

  // receiver holds off while the sender keeps pushing: queue fills, input stalls
  task automatic test_backpressure();
    no_gaps     = 1'b1;
    hold_cycles = 300;
    send_frame(8'h81, 16'd100, 1'b0, $urandom);
    send_frame(HEAD_PING, 16'd6, 1'b0, $urandom);
    send_frame(HEAD_PING, 16'd0, 1'b0, $urandom);
    no_gaps = 1'b0;
  endtask

  // mostly well-formed traffic with random content and random shapes
  task automatic test_random_traffic(input int target);
    int          stop_at;
    int          pick;
    logic [7:0]  hd;
    logic [15:0] len;
    bit          ext16;
    stop_at = n_bytes + target;
    while (n_bytes < stop_at) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      pick    = $urandom_range(0, 99);
      ext16   = 1'b0;
      if (pick < 15) begin
        hd  = HEAD_PING;
        len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 125))
                                          : 16'($urandom_range(0, 8));
      end else if (pick < 25 && !frag_open) begin
        hd  = HEAD_PONG;
        len = 16'($urandom_range(0, 10));
      end else begin
        // keep fragment sequences coherent most of the time
        case ($urandom_range(0, 9))
          0:       hd = {$urandom_range(0, 1) == 1, 5'd0, 2'($urandom_range(0, 2))};
          default: hd = frag_open ? {$urandom_range(0, 2) == 0, 7'h00}
                                  : {$urandom_range(0, 2) != 0, 5'd0,
                                     2'($urandom_range(1, 2))};
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 7)
          len = 16'($urandom_range(0, 12));
        else if (pick < 9)
          len = 16'($urandom_range(13, 125));
        else begin
          len   = 16'($urandom_range(126, 260));
          ext16 = 1'b1;
        end
      end
      send_frame(hd, len, ext16, $urandom);
    end
    no_gaps = 1'b0;
  endtask

  // one protocol error (the seed picks which), then bytes that must vanish
  task automatic test_error_close();
    logic [7:0] bad;
    case ($urandom_range(1, 5))
      1: begin                                     // mask bit clear
        offer_byte(8'h81);
        offer_byte(8'($urandom_range(0, 127)));
      end
      2: begin                                     // 64-bit length code
        offer_byte(8'h82);
        offer_byte({1'b1, LEN_CODE_64});
      end
      3: begin                                     // bad 16-bit length
        if ($urandom_range(0, 1) == 0) begin
          offer_byte(8'h82);
          offer_byte({1'b1, LEN_CODE_16});
          offer_byte(8'h00);
          offer_byte(8'($urandom_range(0, 125)));
        end else begin
          offer_byte(HEAD_PING);
          offer_byte({1'b1, LEN_CODE_16});
          offer_byte(8'($urandom_range(0, 255)));
          offer_byte(8'($urandom_range(0, 255)));
        end
      end
      4: begin                                     // close, reserved bits, etc.
        if ($urandom_range(0, 1) == 0)
          bad = 8'h88;
        else
          do bad = 8'($urandom_range(0, 255));
          while (bad[6:0] <= OP_MAX_DATA || bad == HEAD_PING || bad == HEAD_PONG);
        offer_byte(bad);
        offer_byte({1'b1, 7'($urandom_range(0, 125))});
        repeat (4) offer_byte(8'($urandom_range(0, 255)));
      end
      default: begin                               // pong inside a message
        send_frame(8'h01, 16'd2, 1'b0, $urandom);
        offer_byte(HEAD_PONG);
        offer_byte({1'b1, 7'($urandom_range(0, 125))});
        repeat (4) offer_byte(8'($urandom_range(0, 255)));
      end
    endcase
    repeat (16) offer_byte(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_byte     <= 8'h00;
    no_gaps      = 1'b0;
    hold_cycles  = 0;
    phase        = PH_HEAD;
    head         = 8'h00;
    frame_len    = 16'd0;
    mask_key     = 32'd0;
    pay_idx      = 16'd0;
    frag_open    = 1'b0;
    link_closed  = 1'b0;
    close_code   = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_frames();
    test_ping_pong();
    test_extended_length();
    test_backpressure();
    test_random_traffic(200);
    test_error_close();
    in_valid <= 1'b0;

    // drain, then give the block time to show anything spurious
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes (%0d data frames, %0d pings, %0d pongs), checked %0d results.",
             n_bytes, n_data_frames, n_pings, n_pongs, n_checked);
    $display("Input stalled on %0d cycles; link closed with error code %0d.",
             n_in_stall, close_code);
    if (n_mismatch == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: websocket_frame_deframer_unmasker_unit.f
sv/wsfd_pkg.sv
sv/wsfd_parse.sv
sv/wsfd_outq.sv
sv/websocket_frame_deframer_unmasker_unit.sv
tb/tb.sv
